// ===== src/toq_pkg.sv =====
// ----------------------------------------------------------------------------
// toq_pkg
// Types and codes shared by the time-ordered task queue and its cells.
// ----------------------------------------------------------------------------
package toq_pkg;

  localparam int unsigned HourW = 5;
  localparam int unsigned MinW  = 6;
  localparam int unsigned InfoW = 2;
  localparam int unsigned RefW  = 16;
  localparam int unsigned KeyW  = HourW + MinW;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_POP    = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [InfoW-1:0] info;
    logic [RefW-1:0]  ref_val;
  } slot_t;

  typedef struct packed {
    action_e          action;
    logic [HourW-1:0] task_hour;
    logic [MinW-1:0]  task_minute;
    logic [InfoW-1:0] task_info;
    logic [RefW-1:0]  command_ref;
  } in_item_t;

  typedef struct packed {
    logic             pop_valid;
    logic [HourW-1:0] out_hour;
    logic [MinW-1:0]  out_minute;
    logic [InfoW-1:0] out_info;
    logic [RefW-1:0]  out_command_ref;
    status_e          status;
    logic [4:0]       entry_count;
  } out_item_t;

  // per-transfer command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

  function automatic logic [KeyW-1:0] time_key(input slot_t s);
    return {s.hour, s.minute};
  endfunction

endpackage

// ===== src/toq_cell.sv =====
// ----------------------------------------------------------------------------
// toq_cell
// One queue slot: compares its time with the new task and takes the new
// task, its left neighbor's slot, its right neighbor's slot, or holds.
// ----------------------------------------------------------------------------
module toq_cell import toq_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  slot_t      new_i,
  input  slot_t      left_i,
  input  slot_t      right_i,
  input  logic       occ_i,
  input  logic       left_gt_i,
  output logic       gt_o,
  output slot_t      slot_o
);

  slot_t slot_q, slot_d;

  // empty slots count as later than any task, so the insert point is the
  // first slot that is empty or strictly later
  assign gt_o = !occ_i || (time_key(slot_q) > time_key(new_i));

  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.ins) begin
      if (left_gt_i) begin
        slot_d = left_i;
      end else if (gt_o) begin
        slot_d = new_i;
      end
    end else if (ctrl_i.pop) begin
      slot_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule

// ===== src/time_ordered_task_queue_unit.sv =====
// ----------------------------------------------------------------------------
// time_ordered_task_queue_unit
// Bounded task list kept in time-of-day order by a row of shifting cells.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_ready_o   | in_data_i  (in_item_t)
//  out     | output    | out_valid_o / out_ready_i | out_data_o (out_item_t)
//
//  all cells compare against the new task in parallel and shift right
//  (insert, unless full) or left (pop, unless empty) in the same edge; the
//  result lands in the output register in the cycle after the transfer
//  a new item is taken while a result waits only if that result leaves in
//  the same cycle; reset empties the queue, slot contents are not cleared
// ----------------------------------------------------------------------------
module time_ordered_task_queue_unit import toq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned REF_WIDTH   = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [RefW-1:0] RefMask =
    (REF_WIDTH >= RefW) ? {RefW{1'b1}} : RefW'((64'd1 << REF_WIDTH) - 64'd1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  out_item_t       out_q, out_d;

  logic       xfer, empty, full;
  cell_ctrl_t ctrl;
  slot_t      new_slot;
  slot_t      slots [QUEUE_DEPTH];
  logic       gts   [QUEUE_DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign xfer       = in_valid_i && in_ready_o;
  assign empty      = (count_q == '0);
  assign full       = (count_q == CntW'(QUEUE_DEPTH));

  assign ctrl.ins = xfer && (in_data_i.action == ACT_INSERT) && !full;
  assign ctrl.pop = xfer && (in_data_i.action == ACT_POP) && !empty;

  assign new_slot.hour    = in_data_i.task_hour;
  assign new_slot.minute  = in_data_i.task_minute;
  assign new_slot.info    = in_data_i.task_info;
  assign new_slot.ref_val = in_data_i.command_ref & RefMask;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    slot_t left_s, right_s;
    logic  left_gt;
    if (i == 0) begin : g_first
      assign left_s  = new_slot;
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left_s  = slots[i-1];
      assign left_gt = gts[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_s = slots[i];
    end else begin : g_inner
      assign right_s = slots[i+1];
    end
    toq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .new_i     (new_slot),
      .left_i    (left_s),
      .right_i   (right_s),
      .occ_i     (CntW'(i) < count_q),
      .left_gt_i (left_gt),
      .gt_o      (gts[i]),
      .slot_o    (slots[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    out_d = '0;
    if (ctrl.pop) begin
      out_d.pop_valid       = 1'b1;
      out_d.out_hour        = slots[0].hour;
      out_d.out_minute      = slots[0].minute;
      out_d.out_info        = slots[0].info;
      out_d.out_command_ref = slots[0].ref_val;
    end
    if (in_data_i.action == ACT_POP && empty) begin
      out_d.status = ST_EMPTY;
    end else if (in_data_i.action == ACT_INSERT && full) begin
      out_d.status = ST_FULL;
    end else begin
      out_d.status = ST_OK;
    end
    out_d.entry_count = 5'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pop_valid |-> out_data_o.status == ST_OK)
    else $error("popped task reported with error status");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && in_data_i.action == ACT_POP && empty
    |=> out_data_o.status == ST_EMPTY && count_q == '0)
    else $error("pop from empty queue not flagged");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow the queue");

endmodule
